/* rtl/msd_pkg.sv */
package msd_pkg;

   localparam int NUM_DIGITS = 4;
   localparam int DIGIT_W    = 4;
   localparam int VALUE_W    = 32;
   localparam int SEG_W      = 7;
   localparam int COM_W      = 4;
   localparam int SHOWN_W    = 2;
   localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam int BIT_CNT_W  = $clog2(VALUE_W);

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_CONVERT
   } state_type;

   typedef logic [DIGIT_W-1:0] digit_type;

   function automatic logic [SEG_W-1:0] seg_decode(input digit_type digit);
      logic [SEG_W-1:0] pat;
      unique case (digit)
         4'd0:    pat = 7'h3F;
         4'd1:    pat = 7'h06;
         4'd2:    pat = 7'h5B;
         4'd3:    pat = 7'h4F;
         4'd4:    pat = 7'h66;
         4'd5:    pat = 7'h6D;
         4'd6:    pat = 7'h7D;
         4'd7:    pat = 7'h07;
         4'd8:    pat = 7'h7F;
         4'd9:    pat = 7'h6F;
         default: pat = '0;
      endcase
      return pat;
   endfunction

endpackage

/* rtl/multiplexed_seven_segment_driver.sv */
// channel   direction  handshake          payload
// req_      in         valid / stall      cmd, value
// rsp_      out        valid / stall      segment_lines, common_lines, shown_digit
// csr_      in         valid / ready      common_anode
//
// A tick is written to the output register as it is accepted; a load is accepted and then
// runs through the shift-and-add-3 decimal converter, one value bit a cycle.
// Reset is synchronous, active high: digits, scan index and polarity go to zero.
// req_stall is high while converting and while a result waits under rsp_stall;
// loads and ticks alike are held off while a result waits. csr_ready is always high.
module multiplexed_seven_segment_driver
   import msd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [SEG_W-1:0]   rsp_segment_lines,
   output logic [COM_W-1:0]   rsp_common_lines,
   output logic [SHOWN_W-1:0] rsp_shown_digit,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_common_anode
);

   state_type            state_ff, state_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [VALUE_W-1:0]   bin_ff, bin_in;
   digit_type            digit_store_ff [NUM_DIGITS];
   digit_type            digit_store_in [NUM_DIGITS];
   digit_type            adj [NUM_DIGITS];
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic                 anode_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SEG_W-1:0]     seg_ff, seg_in;
   logic [COM_W-1:0]     com_ff, com_in;
   logic [SHOWN_W-1:0]   shown_ff, shown_in;
   logic [NUM_DIGITS-1:0] onehot;
   logic [NUM_DIGITS-1:0] com_full;
   logic [SEG_W-1:0]     pat;
   logic                 accept;
   logic                 load_go;
   logic                 tick_go;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign load_go   = accept && (req_cmd == CMD_LOAD);
   assign tick_go   = accept && (req_cmd == CMD_TICK);

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         onehot[i] = (scan_ff == IDX_W'(i));
      end
      pat      = seg_decode(digit_store_ff[scan_ff]);
      com_full = anode_ff ? ~onehot : onehot;
   end

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (digit_store_ff[i] >= 4'd5) ? digit_store_ff[i] + 4'd3 : digit_store_ff[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      bin_in       = bin_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      seg_in       = seg_ff;
      com_in       = com_ff;
      shown_in     = shown_ff;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         digit_store_in[i] = digit_store_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (load_go) begin
               state_in   = ST_CONVERT;
               bit_cnt_in = '0;
               bin_in     = req_value;
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  digit_store_in[i] = '0;
               end
            end else if (tick_go) begin
               rsp_valid_in = 1'b1;
               seg_in       = anode_ff ? ~pat : pat;
               com_in       = COM_W'(com_full);
               shown_in     = SHOWN_W'(scan_ff);
               scan_in      = (scan_ff == IDX_W'(NUM_DIGITS - 1)) ? '0 : scan_ff + 1'b1;
            end
         end
         ST_CONVERT: begin
            digit_store_in[0] = {adj[0][DIGIT_W-2:0], bin_ff[VALUE_W-1]};
            for (int i = 1; i < NUM_DIGITS; i++) begin
               digit_store_in[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
            end
            bin_in     = {bin_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         scan_ff      <= '0;
         anode_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_store_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_store_ff[i] <= digit_store_in[i];
         end
         if (csr_valid && csr_ready) begin
            anode_ff <= csr_common_anode;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      seg_ff   <= seg_in;
      com_ff   <= com_in;
      shown_ff <= shown_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_segment_lines = seg_ff;
   assign rsp_common_lines  = com_ff;
   assign rsp_shown_digit   = shown_ff;

endmodule

/* tb/sv/segment_scan_checker.sv */
`timescale 1ns / 100ps

module segment_scan_checker
   import msd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_cmd,
   input  logic [VALUE_W-1:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [SEG_W-1:0]   rsp_segment_lines,
   input  logic [COM_W-1:0]   rsp_common_lines,
   input  logic [SHOWN_W-1:0] rsp_shown_digit,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic               csr_common_anode,
   output int                 outstanding,
   output int                 mismatches
);

   typedef struct packed {
      logic [SEG_W-1:0]   segments;
      logic [COM_W-1:0]   commons;
      logic [SHOWN_W-1:0] shown;
   } frame_type;

   localparam logic [COM_W-1:0] PRESENT = COM_W'((64'd1 << NUM_DIGITS) - 1);

   frame_type   pending_frames [$];
   digit_type   digits [NUM_DIGITS];
   int unsigned scan_pos;
   logic        anode_mode;

   function automatic logic [SEG_W-1:0] glyph_for(input digit_type digit);
      case (digit)
         4'd0:    return 7'h3F;
         4'd1:    return 7'h06;
         4'd2:    return 7'h5B;
         4'd3:    return 7'h4F;
         4'd4:    return 7'h66;
         4'd5:    return 7'h6D;
         4'd6:    return 7'h7D;
         4'd7:    return 7'h07;
         4'd8:    return 7'h7F;
         4'd9:    return 7'h6F;
         default: return '0;
      endcase
   endfunction

   always @(posedge clock) begin
      frame_type          wanted;
      logic [VALUE_W-1:0] rest;
      logic [COM_W-1:0]   lit;
      if (reset) begin
         pending_frames.delete();
         for (int i = 0; i < NUM_DIGITS; i++) digits[i] = '0;
         scan_pos = 0;
         anode_mode = 1'b0;
         mismatches = 0;
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) anode_mode = csr_common_anode;
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_LOAD) begin
               rest = req_value;
               for (int i = 0; i < NUM_DIGITS; i++) begin
                  digits[i] = digit_type'(rest % 10);
                  rest = rest / 10;
               end
            end else begin
               wanted.segments = glyph_for(digits[scan_pos]);
               lit = PRESENT & (COM_W'(1) << scan_pos);
               if (anode_mode) begin
                  wanted.segments = ~wanted.segments;
                  wanted.commons = ~lit & PRESENT;
               end else begin
                  wanted.commons = lit;
               end
               wanted.shown = SHOWN_W'(scan_pos);
               pending_frames.push_back(wanted);
               scan_pos = (scan_pos + 1 >= NUM_DIGITS) ? 0 : scan_pos + 1;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_frames.size() == 0) begin
               $error("unexpected result item: segment_lines %h, common_lines %h, shown_digit %0d",
                      rsp_segment_lines, rsp_common_lines, rsp_shown_digit);
               mismatches++;
            end else begin
               wanted = pending_frames.pop_front();
               if (rsp_segment_lines !== wanted.segments) begin
                  $error("segment_lines: expected %h, actual %h",
                         wanted.segments, rsp_segment_lines);
                  mismatches++;
               end
               if (rsp_common_lines !== wanted.commons) begin
                  $error("common_lines: expected %h, actual %h",
                         wanted.commons, rsp_common_lines);
                  mismatches++;
               end
               if (rsp_shown_digit !== wanted.shown) begin
                  $error("shown_digit: expected %0d, actual %0d",
                         wanted.shown, rsp_shown_digit);
                  mismatches++;
               end
            end
         end
         outstanding <= pending_frames.size();
      end
   end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import msd_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 40;
   localparam int HOLD_CYCLES  = 200;
   localparam int PHASE_ITEMS  = 150;
   localparam int PHASES       = 6;

   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic               req_cmd          = CMD_TICK;
   logic [VALUE_W-1:0] req_value        = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [SEG_W-1:0]   rsp_segment_lines;
   logic [COM_W-1:0]   rsp_common_lines;
   logic [SHOWN_W-1:0] rsp_shown_digit;
   logic               csr_valid        = 1'b0;
   logic               csr_ready;
   logic               csr_common_anode = 1'b0;

   int   outstanding;
   int   mismatches;
   int   cycle_count  = 0;
   int   hold_left    = 0;
   logic steady       = 1'b0;
   logic hold_request = 1'b0;
   logic hold_done    = 1'b0;

   multiplexed_seven_segment_driver DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_segment_lines (rsp_segment_lines),
      .rsp_common_lines  (rsp_common_lines),
      .rsp_shown_digit   (rsp_shown_digit),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_common_anode  (csr_common_anode)
   );

   segment_scan_checker scoreboard (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_segment_lines (rsp_segment_lines),
      .rsp_common_lines  (rsp_common_lines),
      .rsp_shown_digit   (rsp_shown_digit),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_common_anode  (csr_common_anode),
      .outstanding       (outstanding),
      .mismatches        (mismatches)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // hold the result channel for a long stretch once asked, else stall at random outside the steady phase
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < 26);
      end
   end

   task automatic offer_item(input logic cmd, input logic [VALUE_W-1:0] value);
      if (!steady && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid, wait for every result, then let a pending conversion finish
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_polarity(input logic anode);
      quiesce();
      csr_valid        <= 1'b1;
      csr_common_anode <= anode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic               cmd;
      logic [VALUE_W-1:0] value;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_polarity(1'b0);
      offer_item(CMD_LOAD, 32'd0);
      repeat (4) offer_item(CMD_TICK, $urandom());
      offer_item(CMD_LOAD, 32'hFFFF_FFFF);
      repeat (3) offer_item(CMD_TICK, $urandom());
      offer_item(CMD_LOAD, 32'd12345678);
      repeat (5) offer_item(CMD_TICK, $urandom());
      offer_item(CMD_LOAD, 32'd9999);
      offer_item(CMD_LOAD, 32'd1234);
      repeat (4) offer_item(CMD_TICK, $urandom());

      for (int phase = 0; phase < PHASES; phase++) begin
         write_polarity(phase % 2 == 0);
         steady = (phase == 1);
         if (phase == 2) hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            cmd = ($urandom_range(0, 99) < 15) ? CMD_LOAD : CMD_TICK;
            case ($urandom_range(0, 3))
               0:       value = $urandom();
               1:       value = $urandom_range(0, 9999);
               2:       value = $urandom_range(0, 99);
               default: value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            endcase
            offer_item(cmd, value);
         end
      end
      steady = 1'b0;

      quiesce();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/msd_pkg.sv
rtl/multiplexed_seven_segment_driver.sv
tb/sv/segment_scan_checker.sv
tb/sv/testbench.sv
